// ===== rtl/otl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered task list package
// Operation and status codes and the sequencer state type.
// ----------------------------------------------------------------------------
package otl_pkg;

	localparam logic [1:0] FN_INS_CURSOR = 2'd0;
	localparam logic [1:0] FN_INS_SORTED = 2'd1;
	localparam logic [1:0] FN_REMOVE     = 2'd2;

	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_LINKED     = 2'd1;
	localparam logic [1:0] ST_UNLINKED   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_CURSOR,
		S_WALK0,
		S_WALK,
		S_LINK1,
		S_LINK2,
		S_RM_WR,
		S_HEAD_RD,
		S_REPORT
	} state_t;

endpackage

// ===== rtl/otl_if.sv =====
// ----------------------------------------------------------------------------
// Ordered task list channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface otl_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [1:0]  list_id;
	logic [4:0]  item_id;
	logic [31:0] item_key;

	modport source (output valid, func, list_id, item_id, item_key, input ready);
	modport sink   (input valid, func, list_id, item_id, item_key, output ready);
endinterface

interface otl_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [1:0] affected_list;
	logic [5:0] list_count;
	logic       head_valid;
	logic [4:0] head_item;
	logic [5:0] cursor_node;

	modport source (output valid, status, affected_list, list_count, head_valid, head_item,
		cursor_node, input ready);
	modport sink   (input valid, status, affected_list, list_count, head_valid, head_item,
		cursor_node, output ready);
endinterface

// ===== rtl/ordered_task_list_engine.sv =====
// Sequencer states: CHECK, CURSOR, LINK1, LINK2, HEAD_RD, REPORT for insert
// after cursor; CHECK, RM_WR, HEAD_RD, REPORT for remove; CHECK, HEAD_RD,
// REPORT for a refused or unused request; WALK0 and WALK replace CURSOR for
// sorted insert, comparing at most NUM_ITEMS keys, one next/key memory read
// per cycle. One request at a time; the next request is taken the cycle after
// the response is loaded. Reset empties lists, cursors on sentinels; no clear pass.
// ----------------------------------------------------------------------------
// Ordered task list engine
// Circular doubly linked lists over a shared item pool, kept in link and key
// memories and updated by a read-modify-write sequencer.
// ----------------------------------------------------------------------------
module ordered_task_list_engine
	import otl_pkg::*;
#(
	parameter int NUM_ITEMS = 32,
	parameter int NUM_LISTS = 4,
	parameter int KEY_BITS  = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	otl_req_if.sink   req,
	otl_rsp_if.source rsp
);
	localparam int NODES = NUM_ITEMS + NUM_LISTS;
	localparam int NW    = $clog2(NODES);
	localparam int IW    = $clog2(NUM_ITEMS);
	localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
	localparam int CW    = $clog2(NUM_ITEMS + 1);
	localparam int KW    = (KEY_BITS < 32) ? KEY_BITS : 32;

	state_t state_q, state_d;

	logic [1:0]    func_q;
	logic [LW-1:0] l_q;
	logic [IW-1:0] item_q;
	logic [KW-1:0] key_q;
	logic [1:0]    status_q;
	logic [NW-1:0] a_q, b_q, cand_q, at_q;
	logic [CW-1:0] steps_q;

	logic [LW:0]   owner_q  [NUM_ITEMS];
	logic [NW-1:0] cursor_q [NUM_LISTS];
	logic [CW-1:0] count_q  [NUM_LISTS];

	logic [IW-1:0] item_c;
	logic [LW-1:0] list_c;

	logic [NW-1:0] n_rd_addr, n_rd_data, n_wr_addr, n_wr_data;
	logic [NW-1:0] p_rd_addr, p_rd_data, p_wr_addr, p_wr_data;
	logic          n_wr_en, p_wr_en, k_wr_en;
	logic [IW-1:0] k_rd_addr;
	logic [KW-1:0] k_rd_data;

	logic          owned;
	logic          is_insert;
	logic [NW-1:0] item_node;
	logic [NW-1:0] sent_node;
	logic          out_free;
	logic          head_ok;

	// reduce item and list to the pool size
	always_comb begin
		item_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (req.item_id == 5'(i)) begin
				item_c = IW'(i % NUM_ITEMS);
			end
		end
		list_c = '0;
		for (int i = 0; i < 4; i++) begin
			if (req.list_id == 2'(i)) begin
				list_c = LW'(i % NUM_LISTS);
			end
		end
	end

	assign owned     = owner_q[item_q] != '0;
	assign is_insert = (func_q == FN_INS_CURSOR) || (func_q == FN_INS_SORTED);
	assign item_node = NW'(item_q);
	assign sent_node = NW'(NUM_ITEMS) + NW'(l_q);
	assign out_free  = !rsp.valid || rsp.ready;
	assign head_ok   = (count_q[l_q] != '0) && (n_rd_data < NW'(NUM_ITEMS));
	assign req.ready = (state_q == S_IDLE);

	otl_link_mem #(.NUM_ITEMS(NUM_ITEMS), .NUM_LISTS(NUM_LISTS), .NW(NW)) u_next (
		.clk, .arst_n,
		.rd_addr(n_rd_addr), .rd_data(n_rd_data),
		.wr_en(n_wr_en), .wr_addr(n_wr_addr), .wr_data(n_wr_data)
	);

	otl_link_mem #(.NUM_ITEMS(NUM_ITEMS), .NUM_LISTS(NUM_LISTS), .NW(NW)) u_prev (
		.clk, .arst_n,
		.rd_addr(p_rd_addr), .rd_data(p_rd_data),
		.wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data)
	);

	otl_key_mem #(.NUM_ITEMS(NUM_ITEMS), .IW(IW), .KW(KW)) u_key (
		.clk,
		.rd_addr(k_rd_addr), .rd_data(k_rd_data),
		.wr_en(k_wr_en), .wr_addr(item_q), .wr_data(key_q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory ports
	always_comb begin
		state_d   = state_q;
		n_rd_addr = '0;
		p_rd_addr = '0;
		k_rd_addr = '0;
		n_wr_en   = 1'b0;
		n_wr_addr = '0;
		n_wr_data = '0;
		p_wr_en   = 1'b0;
		p_wr_addr = '0;
		p_wr_data = '0;
		k_wr_en   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (is_insert) begin
					if (owned) begin
						state_d = S_HEAD_RD;
					end else begin
						k_wr_en = 1'b1;
						if (func_q == FN_INS_CURSOR) begin
							n_rd_addr = cursor_q[l_q];
							state_d   = S_CURSOR;
						end else begin
							n_rd_addr = sent_node;
							state_d   = S_WALK0;
						end
					end
				end else if (func_q == FN_REMOVE && owned) begin
					n_rd_addr = item_node;
					p_rd_addr = item_node;
					state_d   = S_RM_WR;
				end else begin
					state_d = S_HEAD_RD;
				end
			end
			S_CURSOR: state_d = S_LINK1;
			S_WALK0: begin
				n_rd_addr = n_rd_data;
				k_rd_addr = n_rd_data[IW-1:0];
				state_d   = (n_rd_data >= NW'(NUM_ITEMS)) ? S_LINK1 : S_WALK;
			end
			S_WALK: begin
				n_rd_addr = n_rd_data;
				k_rd_addr = n_rd_data[IW-1:0];
				if (k_rd_data > key_q || steps_q == CW'(NUM_ITEMS - 1) ||
					n_rd_data >= NW'(NUM_ITEMS)) begin
					state_d = S_LINK1;
				end
			end
			S_LINK1: begin
				n_wr_en   = 1'b1;
				n_wr_addr = item_node;
				n_wr_data = b_q;
				p_wr_en   = 1'b1;
				p_wr_addr = item_node;
				p_wr_data = a_q;
				state_d   = S_LINK2;
			end
			S_LINK2: begin
				n_wr_en   = 1'b1;
				n_wr_addr = a_q;
				n_wr_data = item_node;
				p_wr_en   = 1'b1;
				p_wr_addr = b_q;
				p_wr_data = item_node;
				state_d   = S_HEAD_RD;
			end
			S_RM_WR: begin
				n_wr_en   = 1'b1;
				n_wr_addr = p_rd_data;
				n_wr_data = n_rd_data;
				p_wr_en   = 1'b1;
				p_wr_addr = n_rd_data;
				p_wr_data = p_rd_data;
				state_d   = S_HEAD_RD;
			end
			S_HEAD_RD: begin
				n_rd_addr = sent_node;
				state_d   = S_REPORT;
			end
			S_REPORT: begin
				// hold the head read while the response register is busy
				n_rd_addr = sent_node;
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// request and walk registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q   <= req.func;
				l_q      <= list_c;
				item_q   <= item_c;
				key_q    <= req.item_key[KW-1:0];
				status_q <= ST_DONE;
			end
			S_CHECK: begin
				if (is_insert && owned) begin
					status_q <= ST_LINKED;
				end else if (func_q == FN_REMOVE) begin
					if (owned) begin
						l_q <= LW'(owner_q[item_q] - 1'b1);
					end else begin
						status_q <= ST_UNLINKED;
					end
				end
			end
			S_CURSOR: begin
				a_q <= cursor_q[l_q];
				b_q <= n_rd_data;
			end
			S_WALK0: begin
				a_q     <= sent_node;
				b_q     <= n_rd_data;
				at_q    <= sent_node;
				cand_q  <= n_rd_data;
				steps_q <= '0;
			end
			S_WALK: begin
				if (k_rd_data > key_q) begin
					a_q <= at_q;
					b_q <= cand_q;
				end else begin
					// advance onto the candidate
					a_q     <= cand_q;
					b_q     <= n_rd_data;
					at_q    <= cand_q;
					cand_q  <= n_rd_data;
					steps_q <= steps_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_ITEMS; i++) begin
				owner_q[i] <= '0;
			end
			for (int i = 0; i < NUM_LISTS; i++) begin
				cursor_q[i] <= NW'(NUM_ITEMS + i);
				count_q[i]  <= '0;
			end
		end else begin
			if (state_q == S_LINK2) begin
				owner_q[item_q] <= (LW+1)'(l_q) + 1'b1;
				count_q[l_q]    <= count_q[l_q] + 1'b1;
				if (func_q == FN_INS_CURSOR) begin
					cursor_q[l_q] <= item_node;
				end
			end
			if (state_q == S_RM_WR) begin
				owner_q[item_q] <= '0;
				if (count_q[l_q] != '0) begin
					count_q[l_q] <= count_q[l_q] - 1'b1;
				end
				// step the cursor back off the removed item
				if (cursor_q[l_q] == item_node) begin
					cursor_q[l_q] <= p_rd_data;
				end
			end
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (state_q == S_REPORT && out_free) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_REPORT && out_free) begin
			rsp.status        <= status_q;
			rsp.affected_list <= 2'(l_q);
			rsp.list_count    <= 6'(count_q[l_q]);
			rsp.head_valid    <= head_ok;
			rsp.head_item     <= head_ok ? 5'(n_rd_data) : 5'd0;
			rsp.cursor_node   <= 6'(cursor_q[l_q]);
		end
	end

endmodule

// ===== rtl/otl_link_mem.sv =====
// ----------------------------------------------------------------------------
// Link memory
// One link array (next or prev) with a registered read; sentinel entries
// read as themselves until first written.
// ----------------------------------------------------------------------------
module otl_link_mem
	import otl_pkg::*;
#(
	parameter int NUM_ITEMS = 32,
	parameter int NUM_LISTS = 4,
	parameter int NW        = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [NW-1:0] rd_addr,
	output logic [NW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [NW-1:0] wr_addr,
	input  logic [NW-1:0] wr_data
);
	localparam int NODES = NUM_ITEMS + NUM_LISTS;
	localparam int LW    = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;

	logic [NW-1:0] mem [NODES];
	logic [NW-1:0] mem_rd_s1;
	logic [NW-1:0] addr_s1;
	logic          dflt_s1;
	logic          sent_wr_q [NUM_LISTS];
	logic [NW-1:0] rd_off;
	logic [NW-1:0] wr_off;

	assign rd_off = rd_addr - NW'(NUM_ITEMS);
	assign wr_off = wr_addr - NW'(NUM_ITEMS);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		mem_rd_s1 <= mem[rd_addr];
		addr_s1   <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				sent_wr_q[i] <= 1'b0;
			end
			dflt_s1 <= 1'b0;
		end else begin
			if (wr_en && wr_addr >= NW'(NUM_ITEMS)) begin
				sent_wr_q[wr_off[LW-1:0]] <= 1'b1;
			end
			dflt_s1 <= (rd_addr >= NW'(NUM_ITEMS)) && !sent_wr_q[rd_off[LW-1:0]];
		end
	end

	// unwritten sentinel points to itself
	assign rd_data = dflt_s1 ? addr_s1 : mem_rd_s1;

endmodule

// ===== rtl/otl_key_mem.sv =====
// ----------------------------------------------------------------------------
// Key memory
// Per-item ordering keys with a registered read.
// ----------------------------------------------------------------------------
module otl_key_mem
	import otl_pkg::*;
#(
	parameter int NUM_ITEMS = 32,
	parameter int IW        = 5,
	parameter int KW        = 32
) (
	input  logic          clk,
	input  logic [IW-1:0] rd_addr,
	output logic [KW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [IW-1:0] wr_addr,
	input  logic [KW-1:0] wr_data
);
	logic [KW-1:0] mem [NUM_ITEMS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/otl_checker.sv =====
// ----------------------------------------------------------------------------
// Ordered task list checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module otl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [1:0] status,
	input logic [5:0] list_count,
	input logic       head_valid,
	input logic [4:0] head_item
);

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("stalled response changed");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> status != 2'd3)
		else $error("bad status code");

	a_empty_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !head_valid |-> head_item == 5'd0)
		else $error("head item set on empty list");

	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && head_valid |-> list_count != 6'd0)
		else $error("head valid with zero count");

endmodule

bind ordered_task_list_engine otl_checker u_otl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status),
	.list_count (rsp.list_count),
	.head_valid (rsp.head_valid),
	.head_item  (rsp.head_item)
);

// ===== sim/tb_ordered_task_list_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ordered task list engine testbench
// Drives insert, sorted insert and remove requests against a shadow copy of
// the linked lists and compares every response field by field.
// ----------------------------------------------------------------------------
module tb_ordered_task_list_engine;
	import otl_pkg::*;

	localparam int ITEMS = 32;
	localparam int LISTS = 4;
	localparam int NODES = ITEMS + LISTS;
	localparam int STALL_LIMIT = 5000;

	typedef struct packed {
		logic [1:0] status;
		logic [1:0] affected_list;
		logic [5:0] list_count;
		logic       head_valid;
		logic [4:0] head_item;
		logic [5:0] cursor_node;
	} answer_t;

	logic clk;
	logic arst_n;

	otl_req_if req ();
	otl_rsp_if rsp ();

	ordered_task_list_engine uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source)
	);

	// shadow lists
	logic [5:0]  nxt [NODES];
	logic [5:0]  prv [NODES];
	logic [2:0]  owner [ITEMS];
	logic [31:0] keys [ITEMS];
	logic [5:0]  cur [LISTS];
	logic [5:0]  cnt [LISTS];

	answer_t answers_due [$];
	int      send_idle_pct;
	int      recv_stall_pct;
	int      errors;
	int      quiet_cycles;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic answer_t list_summary(logic [1:0] st, int l);
		answer_t a;
		logic [5:0] h;
		h = nxt[ITEMS + l];
		a.status        = st;
		a.affected_list = l[1:0];
		a.list_count    = cnt[l];
		a.head_valid    = (cnt[l] != 0) && (h < ITEMS);
		a.head_item     = a.head_valid ? h[4:0] : 5'd0;
		a.cursor_node   = cur[l];
		return a;
	endfunction

	function automatic void splice_after(int a, int it);
		int b;
		b = nxt[a];
		nxt[it] = b[5:0];
		prv[it] = a[5:0];
		prv[b]  = it[5:0];
		nxt[a]  = it[5:0];
	endfunction

	function automatic answer_t apply_request(logic [1:0] fn, logic [1:0] lid,
		logic [4:0] id, logic [31:0] key);
		int l, it, at, nx, p, n, steps;
		l  = lid;
		it = id;
		if (fn == FN_INS_CURSOR || fn == FN_INS_SORTED) begin
			if (owner[it] != 0)
				return list_summary(ST_LINKED, l);
			keys[it] = key;
			if (fn == FN_INS_CURSOR) begin
				splice_after(cur[l], it);
				cur[l] = it[5:0];
			end else begin
				at = ITEMS + l;
				steps = 0;
				while (steps < ITEMS) begin
					nx = nxt[at];
					if (nx == ITEMS + l || nx >= ITEMS || keys[nx] > key)
						break;
					at = nx;
					steps++;
				end
				splice_after(at, it);
			end
			owner[it] = l[2:0] + 3'd1;
			cnt[l]++;
			return list_summary(ST_DONE, l);
		end
		if (fn == FN_REMOVE) begin
			if (owner[it] == 0)
				return list_summary(ST_UNLINKED, l);
			l = owner[it] - 1;
			p = prv[it];
			n = nxt[it];
			nxt[p] = n[5:0];
			prv[n] = p[5:0];
			if (cur[l] == it)
				cur[l] = p[5:0];
			owner[it] = 3'd0;
			if (cnt[l] != 0)
				cnt[l]--;
			return list_summary(ST_DONE, l);
		end
		return list_summary(ST_DONE, l);
	endfunction

	task automatic send_request(logic [1:0] fn, logic [1:0] lid, logic [4:0] id,
		logic [31:0] key);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.func     <= fn;
		req.list_id  <= lid;
		req.item_id  <= id;
		req.item_key <= key;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		answers_due.push_back(apply_request(fn, lid, id, key));
		req.valid <= 1'b0;
		@(posedge clk);
	endtask

	// response side: stall and check
	always @(posedge clk) begin
		answer_t got, want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.status, rsp.affected_list, rsp.list_count, rsp.head_valid,
					rsp.head_item, rsp.cursor_node};
				if (answers_due.size() == 0) begin
					$error("unexpected response");
					errors++;
				end else begin
					want = answers_due.pop_front();
					if (got.status !== want.status) begin
						$error("status exp %0d got %0d", want.status, got.status);
						errors++;
					end
					if (got.affected_list !== want.affected_list) begin
						$error("affected_list exp %0d got %0d", want.affected_list,
							got.affected_list);
						errors++;
					end
					if (got.list_count !== want.list_count) begin
						$error("list_count exp %0d got %0d", want.list_count, got.list_count);
						errors++;
					end
					if (got.head_valid !== want.head_valid) begin
						$error("head_valid exp %0d got %0d", want.head_valid, got.head_valid);
						errors++;
					end
					if (got.head_item !== want.head_item) begin
						$error("head_item exp %0d got %0d", want.head_item, got.head_item);
						errors++;
					end
					if (got.cursor_node !== want.cursor_node) begin
						$error("cursor_node exp %0d got %0d", want.cursor_node, got.cursor_node);
						errors++;
					end
				end
			end
			rsp.ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
		end else begin
			rsp.ready <= 1'b0;
		end
	end

	// watchdog on accepted requests and responses
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("ordered_task_list_engine: mismatch");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(FN_REMOVE, 2'd1, 5'd0, 32'd0);          // remove from empty pool
		send_request(FN_INS_CURSOR, 2'd0, 5'd0, 32'hFFFF_FFFF);
		send_request(FN_INS_CURSOR, 2'd0, 5'd31, 32'd0);
		send_request(FN_INS_CURSOR, 2'd2, 5'd31, 32'd5);      // already linked
		send_request(FN_INS_SORTED, 2'd3, 5'd5, 32'd10);
		send_request(FN_INS_SORTED, 2'd3, 5'd6, 32'd10);      // equal key goes after
		send_request(FN_INS_SORTED, 2'd3, 5'd7, 32'd0);
		send_request(FN_INS_SORTED, 2'd3, 5'd8, 32'hFFFF_FFFF);
		send_request(FN_INS_SORTED, 2'd3, 5'd0, 32'd1);       // already linked
		send_request(2'd3, 2'd3, 5'd9, 32'hA5A5_5A5A);        // unused operation
		send_request(FN_REMOVE, 2'd2, 5'd31, 32'd0);          // cursor steps back
		send_request(FN_REMOVE, 2'd0, 5'd0, 32'd0);           // list empties
		send_request(FN_REMOVE, 2'd0, 5'd7, 32'd0);           // head of sorted list
		send_request(FN_INS_CURSOR, 2'd1, 5'd1, 32'd3);
		send_request(FN_INS_SORTED, 2'd1, 5'd2, 32'd2);
		send_request(FN_REMOVE, 2'd3, 5'd1, 32'd0);
		send_request(FN_REMOVE, 2'd3, 5'd2, 32'd0);
	endtask

	task automatic test_random(int n);
		logic [1:0]  fn;
		logic [31:0] key;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0:             fn = 2'd3;
				1, 2, 3, 4, 5: fn = FN_INS_CURSOR;
				6, 7, 8, 9, 10, 11, 12: fn = FN_INS_SORTED;
				default:       fn = FN_REMOVE;
			endcase
			// mix narrow keys (ties) with full-range keys
			key = $urandom_range(3) == 0 ? 32'($urandom_range(7)) : $urandom;
			send_request(fn, 2'($urandom_range(3)), 5'($urandom_range(31)), key);
		end
	endtask

	task automatic test_idle_phase(int sp, int rp, int n);
		send_idle_pct  = sp;
		recv_stall_pct = rp;
		test_random(n);
	endtask

	initial begin
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.func = FN_INS_CURSOR;
		req.list_id = 2'd0;
		req.item_id = 5'd0;
		req.item_key = 32'd0;
		for (int i = 0; i < NODES; i++) begin
			nxt[i] = i[5:0];
			prv[i] = i[5:0];
		end
		for (int i = 0; i < ITEMS; i++) begin
			owner[i] = 3'd0;
			keys[i] = 32'd0;
		end
		for (int l = 0; l < LISTS; l++) begin
			cur[l] = 6'(ITEMS + l);
			cnt[l] = 6'd0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_idle_phase(0, 0, 400);
		test_idle_phase(60, 0, 350);
		test_idle_phase(0, 60, 350);
		test_idle_phase(14, 14, 350);

		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("ordered_task_list_engine: match");
		else
			$display("ordered_task_list_engine: mismatch");
		$finish;
	end

endmodule
